// ===== rtl/core/a85_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascii85 encoder package
// Shared word types, converter states and constants of the Ascii85 encoder.
// ----------------------------------------------------------------------------
package a85_pkg;

    localparam int GROUP_W     = 32;
    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 3;
    localparam int GROUP_CHARS = 5;
    localparam int DIV_STEPS   = 4;
    localparam int STEP_W      = 2;
    localparam int IDX_W       = 3;

    // floor(x / 85) == (x * DIV85_MUL) >> DIV85_SHIFT for every 32-bit x.
    localparam logic [GROUP_W-1:0] DIV85_MUL = 32'd3233857729;
    localparam int DIV85_SHIFT = 38;
    localparam int PROD_W      = 2 * GROUP_W;
    localparam int QUOT_W      = PROD_W - DIV85_SHIFT;

    localparam logic [CHAR_W-1:0] BASE85    = 7'd85;
    localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd33;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd122;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              run_end;
        logic              stream_end;
    } out_word_t;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [COUNT_W-1:0] char_count;
        logic               zero_grp;
        logic               fin;
    } grp_cmd_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_MUL,
        CV_REM,
        CV_DONE
    } cv_state_t;

endpackage

// ===== rtl/core/a85_front.sv =====
// ----------------------------------------------------------------------------
// Ascii85 front end
// Packs input bytes big endian into a group and issues one command per
// finished group with its character count and zero-group flag.
// ----------------------------------------------------------------------------
module a85_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  a85_pkg::in_word_t   s_word,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output a85_pkg::grp_cmd_t   cmd
);

    logic [1:0]                   pos_reg;
    logic [a85_pkg::GROUP_W-1:0]  acc_reg;
    logic                         cmd_valid_reg;
    a85_pkg::grp_cmd_t            cmd_reg;

    logic                         accept;
    logic                         emit;
    logic [a85_pkg::GROUP_W-1:0]  group_next;
    logic                         cmd_valid_next;

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;
    assign emit    = (pos_reg == 2'd3) || s_word.end_of_input;

    assign group_next = acc_reg | ({s_word.data_byte, 24'd0} >> {pos_reg, 3'b000});
    assign cmd_valid_next = (cmd_valid_reg && !cmd_ready) || (accept && emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            acc_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            if (accept) begin
                if (emit) begin
                    pos_reg <= 2'd0;
                    acc_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                    acc_reg <= group_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            cmd_reg.group    <= group_next;
            cmd_reg.fin      <= s_word.end_of_input;
            cmd_reg.zero_grp <= (pos_reg == 2'd3) && !s_word.end_of_input
                                && (group_next == '0);
            if (pos_reg == 2'd3) begin
                cmd_reg.char_count <= a85_pkg::COUNT_W'(a85_pkg::GROUP_CHARS);
            end else begin
                cmd_reg.char_count <= {1'b0, pos_reg} + 3'd2;
            end
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

`ifndef ASSERT_OFF
    // A finished group always leaves the packer empty.
    a_group_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit |=> pos_reg == 2'd0 && acc_reg == '0)
        else $error("packer not cleared after group");
`endif

endmodule

// ===== rtl/core/a85_queue.sv =====
// ----------------------------------------------------------------------------
// Ascii85 command queue
// Short first-in first-out buffer of group commands between the front end
// and the converter.
// ----------------------------------------------------------------------------
module a85_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  a85_pkg::grp_cmd_t   in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output a85_pkg::grp_cmd_t   out_cmd
);

    a85_pkg::grp_cmd_t                mem_reg [a85_pkg::QUEUE_DEPTH];
    logic [a85_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [a85_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [a85_pkg::QUEUE_CNT_W-1:0]  cnt_reg;

    logic push;
    logic pop;

    assign in_ready  = cnt_reg != a85_pkg::QUEUE_CNT_W'(a85_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                if (wr_ptr_reg == a85_pkg::QUEUE_PTR_W'(a85_pkg::QUEUE_DEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (pop) begin
                if (rd_ptr_reg == a85_pkg::QUEUE_PTR_W'(a85_pkg::QUEUE_DEPTH - 1)) begin
                    rd_ptr_reg <= '0;
                end else begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/a85_back.sv =====
// ----------------------------------------------------------------------------
// Ascii85 back end
// Converts a group into base-85 characters with a shared divide-by-85 unit
// and sends them out, most significant first, through an output register.
// ----------------------------------------------------------------------------
module a85_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  a85_pkg::grp_cmd_t   cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output a85_pkg::out_word_t  m_word
);

    a85_pkg::cv_state_t               state_reg;
    a85_pkg::cv_state_t               state_next;

    logic [a85_pkg::GROUP_W-1:0]      cv_val_reg;
    logic [a85_pkg::PROD_W-1:0]       prod_reg;
    logic [a85_pkg::STEP_W-1:0]       step_reg;
    logic [a85_pkg::COUNT_W-1:0]      cv_count_reg;
    logic                             cv_fin_reg;
    logic [a85_pkg::CHAR_W-1:0]       cv_chars_reg [a85_pkg::GROUP_CHARS];

    logic [a85_pkg::COUNT_W-1:0]      em_left_reg;
    logic                             em_fin_reg;
    logic [a85_pkg::CHAR_W-1:0]       em_chars_reg [a85_pkg::GROUP_CHARS];

    logic                             cv_load;
    logic                             em_load;
    logic                             em_free;
    logic                             last_step;
    logic [a85_pkg::GROUP_W-1:0]      mul_a;
    logic [a85_pkg::PROD_W-1:0]       mul_p;
    logic [a85_pkg::QUOT_W-1:0]       quot;
    logic [a85_pkg::GROUP_W:0]        quot_x85;
    logic [a85_pkg::GROUP_W-1:0]      rem_full;
    logic [a85_pkg::IDX_W-1:0]        wr_idx;

    assign em_free   = (em_left_reg == '0) || ((em_left_reg == 3'd1) && m_ready);
    assign last_step = step_reg == a85_pkg::STEP_W'(a85_pkg::DIV_STEPS - 1);

    assign mul_a    = cv_load ? cmd.group : cv_val_reg;
    assign mul_p    = a85_pkg::PROD_W'(mul_a) * a85_pkg::PROD_W'(a85_pkg::DIV85_MUL);
    assign quot     = prod_reg[a85_pkg::DIV85_SHIFT +: a85_pkg::QUOT_W];
    assign quot_x85 = (a85_pkg::GROUP_W + 1)'(quot) * (a85_pkg::GROUP_W + 1)'(a85_pkg::BASE85);
    assign rem_full = cv_val_reg - quot_x85[a85_pkg::GROUP_W-1:0];
    assign wr_idx   = a85_pkg::IDX_W'(a85_pkg::GROUP_CHARS - 1) - {1'b0, step_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            a85_pkg::CV_IDLE: begin
                if (cmd_valid) begin
                    state_next = cmd.zero_grp ? a85_pkg::CV_DONE : a85_pkg::CV_REM;
                end
            end
            a85_pkg::CV_MUL: begin
                state_next = a85_pkg::CV_REM;
            end
            a85_pkg::CV_REM: begin
                state_next = last_step ? a85_pkg::CV_DONE : a85_pkg::CV_MUL;
            end
            a85_pkg::CV_DONE: begin
                if (em_free) begin
                    if (cmd_valid) begin
                        state_next = cmd.zero_grp ? a85_pkg::CV_DONE : a85_pkg::CV_REM;
                    end else begin
                        state_next = a85_pkg::CV_IDLE;
                    end
                end
            end
            default: begin
                state_next = a85_pkg::CV_IDLE;
            end
        endcase
    end

    always_comb begin
        cv_load = 1'b0;
        em_load = 1'b0;
        unique case (state_reg)
            a85_pkg::CV_IDLE: begin
                cv_load = cmd_valid;
            end
            a85_pkg::CV_DONE: begin
                em_load = em_free;
                cv_load = em_free && cmd_valid;
            end
            default: begin
                cv_load = 1'b0;
            end
        endcase
    end

    assign cmd_ready = cv_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= a85_pkg::CV_IDLE;
            em_left_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (em_load) begin
                em_left_reg <= cv_count_reg;
            end else if (m_valid && m_ready) begin
                em_left_reg <= em_left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cv_load) begin
            cv_val_reg   <= cmd.group;
            prod_reg     <= mul_p;
            step_reg     <= '0;
            cv_fin_reg   <= cmd.fin;
            cv_count_reg <= cmd.zero_grp ? 3'd1 : cmd.char_count;
            if (cmd.zero_grp) begin
                cv_chars_reg[0] <= a85_pkg::CHAR_ZERO;
            end
        end else if (state_reg == a85_pkg::CV_REM) begin
            cv_chars_reg[wr_idx] <= rem_full[a85_pkg::CHAR_W-1:0] + a85_pkg::CHAR_BASE;
            cv_val_reg           <= a85_pkg::GROUP_W'(quot);
            step_reg             <= step_reg + 1'b1;
            if (last_step) begin
                cv_chars_reg[0] <= quot[a85_pkg::CHAR_W-1:0] + a85_pkg::CHAR_BASE;
            end
        end else if (state_reg == a85_pkg::CV_MUL) begin
            prod_reg <= mul_p;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_load) begin
            em_chars_reg <= cv_chars_reg;
            em_fin_reg   <= cv_fin_reg;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < a85_pkg::GROUP_CHARS - 1; i++) begin
                em_chars_reg[i] <= em_chars_reg[i+1];
            end
        end
    end

    assign m_valid           = em_left_reg != '0;
    assign m_word.char_code  = em_chars_reg[0];
    assign m_word.run_end    = em_left_reg == 3'd1;
    assign m_word.stream_end = (em_left_reg == 3'd1) && em_fin_reg;

`ifndef ASSERT_OFF
    // The reciprocal multiply must leave a true base-85 remainder.
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == a85_pkg::CV_REM |-> rem_full < 32'd85)
        else $error("remainder out of base-85 range");

    // The most significant digit of a group never exceeds 84.
    a_top_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == a85_pkg::CV_REM && last_step |-> quot < 26'd85)
        else $error("leading digit out of range");

    // A zero group handed to the output appears as one 'z' that ends its run.
    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        em_load && cv_count_reg == 3'd1 && cv_chars_reg[0] == a85_pkg::CHAR_ZERO
        |=> m_valid && m_word.run_end)
        else $error("zero group not sent as a single word");
`endif

endmodule

// ===== rtl/core/ascii85_encoder.sv =====
// ----------------------------------------------------------------------------
// Ascii85 encoder
// Streaming base-85 encoder: one input byte per word, one character per
// output word.
// ----------------------------------------------------------------------------
// The s_ channel takes one byte per word with an end-of-stream flag. The
// m_ channel gives one character per word, with run_end on the last
// character of each group and stream_end on the last character
// of the stream. Both channels use valid and ready.
// Bytes are packed into four-byte groups by the front end. Each finished
// group is queued and then converted by one shared divide-by-85 unit,
// a reciprocal multiply followed by a remainder step, four passes per group.
// Bytes are still taken while a group converts, until the queue fills;
// an all-zero group skips the divide passes and gives 'z'.
// The first character of a group is offered once the group has passed
// the command register, the queue, the converter and the output register.
// Characters leave from an output register while the next group converts.
// When the receiver stalls, the converter, then the two-entry queue and
// finally the byte input fill up and s_ready drops.
// Reset, synchronous and active low, empties the group, queue and output.
// ----------------------------------------------------------------------------
module ascii85_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  a85_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output a85_pkg::out_word_t  m_word
);

    logic               fr_valid;
    logic               fr_ready;
    a85_pkg::grp_cmd_t  fr_cmd;
    logic               bk_valid;
    logic               bk_ready;
    a85_pkg::grp_cmd_t  bk_cmd;

    a85_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    a85_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_cmd   (bk_cmd)
    );

    a85_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd       (bk_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule
